@@ hdl/xyli_pkg.sv @@
`timescale 1ns / 1ps

package xyli_pkg;

  // Item kind carried in the input tuser
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_X_DIR_POL = 2'd0,
    CFG_Y_DIR_POL = 2'd1,
    CFG_X_LIMIT   = 2'd2,
    CFG_Y_LIMIT   = 2'd3
  } cfg_reg_e;

  // Bit positions of the result flags inside the output tdata
  localparam int unsigned RES_STEP_X = 0;
  localparam int unsigned RES_STEP_Y = 1;
  localparam int unsigned RES_DIR_X  = 2;
  localparam int unsigned RES_DIR_Y  = 3;
  localparam int unsigned RES_BUSY   = 4;
  localparam int unsigned RES_DONE   = 5;
  localparam int unsigned RES_FLAGS  = 6;

  // Per-item status flags from the stepping core
  typedef struct packed {
    logic done;
    logic busy;
    logic dir_y;
    logic dir_x;
    logic step_y;
    logic step_x;
  } flags_t;

endpackage

@@ hdl/xyli_cfg.sv @@
`timescale 1ns / 1ps

module xyli_cfg #(
  parameter int unsigned POS_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  xyli_pkg::cfg_reg_e   wr_index_i,
  input  logic [POS_BITS-2:0]  wr_data_i,
  output logic                 x_pol_o,
  output logic                 y_pol_o,
  output logic [POS_BITS-2:0]  x_lim_o,
  output logic [POS_BITS-2:0]  y_lim_o
);
  import xyli_pkg::*;

  logic                x_pol_q, y_pol_q;
  logic [POS_BITS-2:0] x_lim_q, y_lim_q;

  // Take one register write per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_pol_q <= 1'b0;
      y_pol_q <= 1'b0;
      x_lim_q <= '1;
      y_lim_q <= '1;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_X_DIR_POL: x_pol_q <= wr_data_i[0];
        CFG_Y_DIR_POL: y_pol_q <= wr_data_i[0];
        CFG_X_LIMIT:   x_lim_q <= wr_data_i;
        CFG_Y_LIMIT:   y_lim_q <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign x_pol_o = x_pol_q;
  assign y_pol_o = y_pol_q;
  assign x_lim_o = x_lim_q;
  assign y_lim_o = y_lim_q;

endmodule

@@ hdl/xyli_core.sv @@
`timescale 1ns / 1ps

module xyli_core #(
  parameter int unsigned POS_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  xyli_pkg::op_e               op_i,
  input  logic                        rel_i,
  input  logic signed [POS_BITS-1:0]  tgt_x_i,
  input  logic signed [POS_BITS-1:0]  tgt_y_i,
  input  logic                        x_pol_i,
  input  logic                        y_pol_i,
  input  logic        [POS_BITS-2:0]  x_lim_i,
  input  logic        [POS_BITS-2:0]  y_lim_i,
  output xyli_pkg::flags_t            flags_o,
  output logic signed [POS_BITS-1:0]  pos_x_o,
  output logic signed [POS_BITS-1:0]  pos_y_o
);
  import xyli_pkg::*;

  localparam int unsigned DLT_BITS = POS_BITS + 1;
  localparam int unsigned ERR_BITS = POS_BITS + 3;
  localparam int unsigned E2_BITS  = ERR_BITS + 1;

  // Move state
  logic signed [POS_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [POS_BITS-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic signed [DLT_BITS-1:0] abs_dx_q, abs_dx_d, neg_dy_q, neg_dy_d;
  logic signed [ERR_BITS-1:0] err_q, err_d;
  logic sign_x_q, sign_x_d, sign_y_q, sign_y_d;
  logic pin_x_q, pin_x_d, pin_y_q, pin_y_d;
  logic phase_q, phase_d, moving_q, moving_d;

  // Start path
  logic signed [POS_BITS-1:0] st_tx, st_ty;
  logic signed [DLT_BITS-1:0] ddx, ddy, st_abs_dx, st_neg_dy;
  logic signed [ERR_BITS-1:0] st_err;
  logic                       ddx_pos, ddy_pos;

  // Tick path
  logic signed [E2_BITS-1:0]  e2;
  logic                       tst_x, tst_y;
  logic signed [POS_BITS-1:0] nx, ny, lim_x, lim_y;
  logic                       pul_x, pul_y;
  logic signed [ERR_BITS-1:0] add_x, add_y, err_tick;
  logic                       reached;
  logic                       px, py, done;

  // Plan a move: goal, signs, deltas and the starting error
  always_comb begin
    st_tx     = rel_i ? cur_x_q + tgt_x_i : tgt_x_i;
    st_ty     = rel_i ? cur_y_q + tgt_y_i : tgt_y_i;
    ddx       = DLT_BITS'(st_tx) - DLT_BITS'(cur_x_q);
    ddy       = DLT_BITS'(st_ty) - DLT_BITS'(cur_y_q);
    ddx_pos   = !ddx[DLT_BITS-1] && (ddx != '0);
    ddy_pos   = !ddy[DLT_BITS-1] && (ddy != '0);
    st_abs_dx = ddx_pos ? ddx : -ddx;
    st_neg_dy = ddy_pos ? -ddy : ddy;
    st_err    = ERR_BITS'(st_abs_dx) + ERR_BITS'(st_neg_dy);
  end

  // Error test and one-tick position advance per axis
  always_comb begin
    e2      = {err_q, 1'b0};
    tst_x   = e2 >= E2_BITS'(neg_dy_q);
    tst_y   = e2 <= E2_BITS'(abs_dx_q);
    nx      = sign_x_q ? cur_x_q - POS_BITS'(1) : cur_x_q + POS_BITS'(1);
    ny      = sign_y_q ? cur_y_q - POS_BITS'(1) : cur_y_q + POS_BITS'(1);
    lim_x   = {1'b0, x_lim_i};
    lim_y   = {1'b0, y_lim_i};
    pul_x   = pin_x_q ? (nx < lim_x) : (!nx[POS_BITS-1] && (nx != '0));
    pul_y   = pin_y_q ? (ny < lim_y) : (!ny[POS_BITS-1] && (ny != '0));
    add_x   = tst_x ? ERR_BITS'(neg_dy_q) : '0;
    add_y   = tst_y ? ERR_BITS'(abs_dx_q) : '0;
    err_tick = err_q + add_x + add_y;
    reached = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
  end

  // Next state for the item in flight
  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    abs_dx_d = abs_dx_q;
    neg_dy_d = neg_dy_q;
    err_d    = err_q;
    sign_x_d = sign_x_q;
    sign_y_d = sign_y_q;
    pin_x_d  = pin_x_q;
    pin_y_d  = pin_y_q;
    phase_d  = phase_q;
    moving_d = moving_q;
    px       = 1'b0;
    py       = 1'b0;
    done     = 1'b0;
    if (en_i) begin
      if (op_i == OP_START) begin
        goal_x_d = st_tx;
        goal_y_d = st_ty;
        sign_x_d = !ddx_pos;
        sign_y_d = !ddy_pos;
        pin_x_d  = ddx_pos ? x_pol_i : !x_pol_i;
        pin_y_d  = ddy_pos ? y_pol_i : !y_pol_i;
        abs_dx_d = st_abs_dx;
        neg_dy_d = st_neg_dy;
        err_d    = st_err;
        moving_d = 1'b1;
      end else if (moving_q) begin
        if (reached) begin
          moving_d = 1'b0;
          done     = 1'b1;
        end else begin
          if (!phase_q) begin
            if (tst_x) begin
              cur_x_d = nx;
              px      = pul_x;
            end
            if (tst_y) begin
              cur_y_d = ny;
              py      = pul_y;
            end
            err_d = err_tick;
          end
          phase_d = !phase_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      abs_dx_q <= '0;
      neg_dy_q <= '0;
      err_q    <= '0;
      sign_x_q <= 1'b0;
      sign_y_q <= 1'b0;
      pin_x_q  <= 1'b0;
      pin_y_q  <= 1'b0;
      phase_q  <= 1'b0;
      moving_q <= 1'b0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      goal_x_q <= goal_x_d;
      goal_y_q <= goal_y_d;
      abs_dx_q <= abs_dx_d;
      neg_dy_q <= neg_dy_d;
      err_q    <= err_d;
      sign_x_q <= sign_x_d;
      sign_y_q <= sign_y_d;
      pin_x_q  <= pin_x_d;
      pin_y_q  <= pin_y_d;
      phase_q  <= phase_d;
      moving_q <= moving_d;
    end
  end

  // Result of this item, taken by the output register
  always_comb begin
    flags_o.step_x = px;
    flags_o.step_y = py;
    flags_o.dir_x  = pin_x_d;
    flags_o.dir_y  = pin_y_d;
    flags_o.busy   = moving_d;
    flags_o.done   = done;
  end

  assign pos_x_o = cur_x_d;
  assign pos_y_o = cur_y_d;

endmodule

@@ hdl/xy_stepper_line_interpolator.sv @@
`timescale 1ns / 1ps
// An item is captured in the input register and its result is held in the result register.
// One item per cycle unless the result stalls; the position/error state updates per item.
// The output register lets a new item enter while a finished result waits for m_axis_tready.
// Reset (rst_ni low, asynchronous) clears position, goal, error, phase and move state,
// sets polarities to 0 and both limits to all ones, and empties both register stages.
module xy_stepper_line_interpolator #(
  parameter int unsigned POS_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // target_x, target_y, zero pad
  input  logic [((2*POS_BITS+7)/8)*8-1:0] s_axis_tdata,
  // operation, relative
  input  logic [1:0]                 s_axis_tuser,
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // step_x, step_y, dir_x, dir_y, busy_res, done_res, pos_x, pos_y, zero pad
  output logic [((2*POS_BITS+6+7)/8)*8-1:0] m_axis_tdata,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  xyli_pkg::cfg_reg_e         cfg_index_i,
  input  logic [POS_BITS-2:0]        cfg_data_i
);
  import xyli_pkg::*;

  localparam int unsigned OUT_BITS = ((2*POS_BITS+6+7)/8)*8;
  localparam int unsigned RES_BITS = RES_FLAGS + 2*POS_BITS;

  logic                       s_fire, adv;
  logic                       in_vld_q, in_vld_d;
  op_e                        in_op_q;
  logic                       in_rel_q;
  logic signed [POS_BITS-1:0] in_tx_q, in_ty_q;
  logic                       m_vld_q, m_vld_d;
  logic [RES_BITS-1:0]        res_q;
  logic                       x_pol, y_pol;
  logic [POS_BITS-2:0]        x_lim, y_lim;
  flags_t                     flags;
  logic signed [POS_BITS-1:0] pos_x, pos_y;

  // Stage handshake: advance when the result register is free or being drained
  assign adv           = in_vld_q && (!m_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    m_vld_d = m_vld_q;
    if (adv) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      m_vld_q  <= m_vld_d;
    end
  end

  // Capture the input item on each transfer
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_op_q  <= op_e'(s_axis_tuser[0]);
      in_rel_q <= s_axis_tuser[1];
      in_tx_q  <= s_axis_tdata[POS_BITS-1:0];
      in_ty_q  <= s_axis_tdata[2*POS_BITS-1:POS_BITS];
    end
  end

  xyli_cfg #(
    .POS_BITS (POS_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .x_pol_o    (x_pol),
    .y_pol_o    (y_pol),
    .x_lim_o    (x_lim),
    .y_lim_o    (y_lim)
  );

  xyli_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .op_i    (in_op_q),
    .rel_i   (in_rel_q),
    .tgt_x_i (in_tx_q),
    .tgt_y_i (in_ty_q),
    .x_pol_i (x_pol),
    .y_pol_i (y_pol),
    .x_lim_i (x_lim),
    .y_lim_i (y_lim),
    .flags_o (flags),
    .pos_x_o (pos_x),
    .pos_y_o (pos_y)
  );

  // Hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= {pos_y, pos_x, flags.done, flags.busy, flags.dir_y, flags.dir_x,
                flags.step_y, flags.step_x};
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = OUT_BITS'(res_q);

endmodule

@@ hdl/xyli_checker.sv @@
`timescale 1ns / 1ps

module xyli_assert #(
  parameter int unsigned POS_BITS = 24
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((2*POS_BITS+6+7)/8)*8-1:0]   m_axis_tdata
);
  import xyli_pkg::*;

  logic out_fire, out_step, prev_step_q;

  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign out_step = m_axis_tdata[RES_STEP_X] || m_axis_tdata[RES_STEP_Y];

  // Remember whether the last delivered result carried a pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_step_q <= 1'b0;
    end else if (out_fire) begin
      prev_step_q <= out_step;
    end
  end

  // A stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Done ends the move and carries no pulse
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[RES_DONE] |-> !m_axis_tdata[RES_BUSY] && !out_step)
    else $error("done with busy or step");

  // Pulses come only during a move
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_step |-> m_axis_tdata[RES_BUSY])
    else $error("step while not busy");

  // Pulses alternate: two results in a row never both step
  a_alt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && prev_step_q |-> !out_step)
    else $error("step pulses not alternating");

endmodule

bind xy_stepper_line_interpolator xyli_assert #(.POS_BITS(POS_BITS)) u_xyli_assert (.*);

@@ tb/sv/xyli_checker.sv @@
`timescale 1ns / 1ps

module xyli_checker #(
  parameter int unsigned POS_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  input  logic                                  s_axis_tready,
  input  logic [((2*POS_BITS+7)/8)*8-1:0]       s_axis_tdata,
  input  logic [1:0]                            s_axis_tuser,
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic [((2*POS_BITS+6+7)/8)*8-1:0]     m_axis_tdata,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_o,
  input  xyli_pkg::cfg_reg_e                    cfg_index_i,
  input  logic [POS_BITS-2:0]                   cfg_data_i,
  output int unsigned                           errors_o,
  output int unsigned                           outstanding_o,
  output int unsigned                           checked_o
);
  import xyli_pkg::*;

  localparam int unsigned OUT_W  = ((2*POS_BITS+6+7)/8)*8;
  localparam int unsigned PAD_LO = RES_FLAGS + 2*POS_BITS;
  localparam int unsigned RUN_W  = POS_BITS + 2;
  localparam int unsigned ERR_W  = POS_BITS + 3;

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] pos_x;
    flags_t                     flags;
  } step_outcome_t;

  // Register copies
  logic                pol_x, pol_y;
  logic [POS_BITS-2:0] lim_x, lim_y;

  // Line state
  logic signed [POS_BITS-1:0] cur_x, cur_y, goal_x, goal_y;
  logic signed [RUN_W-1:0]    run_x;    // |dx|
  logic signed [RUN_W-1:0]    rise_y;   // -|dy|
  logic signed [ERR_W-1:0]    err;
  logic                       back_x, back_y;   // 1 = stepping toward minus
  logic                       pin_x, pin_y, phase, moving;

  step_outcome_t step_outcomes_q[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors_o++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Advance the line state by one item and queue the outcome it should produce
  task automatic interpolate_item(input op_e op, input logic rel,
                                  input logic signed [POS_BITS-1:0] tx,
                                  input logic signed [POS_BITS-1:0] ty);
    step_outcome_t           o;
    logic signed [POS_BITS:0] dx, dy;
    logic signed [ERR_W:0]    twice;
    o = '0;
    if (op == OP_START) begin
      // offsets wrap at the position width
      if (rel) begin
        tx = cur_x + tx;
        ty = cur_y + ty;
      end
      goal_x = tx;
      goal_y = ty;
      dx = goal_x - cur_x;
      dy = goal_y - cur_y;
      // a zero delta counts as minus
      back_x = !(dx > 0);
      pin_x  = back_x ? !pol_x : pol_x;
      run_x  = back_x ? -dx : dx;
      back_y = !(dy > 0);
      pin_y  = back_y ? !pol_y : pol_y;
      rise_y = back_y ? dy : -dy;
      err    = run_x + rise_y;
      moving = 1'b1;
    end else if (moving) begin
      if (cur_x == goal_x && cur_y == goal_y) begin
        moving       = 1'b0;
        o.flags.done = 1'b1;
      end else begin
        // error test only on the low half of the pulse
        if (!phase) begin
          twice = {err, 1'b0};
          if (twice >= rise_y) begin
            err   = err + rise_y;
            cur_x = back_x ? cur_x - 1 : cur_x + 1;
            o.flags.step_x = pin_x ? (cur_x < $signed({1'b0, lim_x})) : (cur_x > 0);
          end
          if (twice <= run_x) begin
            err   = err + run_x;
            cur_y = back_y ? cur_y - 1 : cur_y + 1;
            o.flags.step_y = pin_y ? (cur_y < $signed({1'b0, lim_y})) : (cur_y > 0);
          end
        end
        phase = !phase;
      end
    end
    o.flags.dir_x = pin_x;
    o.flags.dir_y = pin_y;
    o.flags.busy  = moving;
    o.pos_x       = cur_x;
    o.pos_y       = cur_y;
    step_outcomes_q.push_back(o);
  endtask

  // Compare one result transfer against the oldest outcome
  task automatic compare_result(input logic [OUT_W-1:0] word);
    step_outcome_t              want;
    flags_t                     f;
    logic signed [POS_BITS-1:0] px, py;
    if (step_outcomes_q.size() == 0) begin
      report_mismatch("result with none outstanding", 1, 0);
    end else begin
      want = step_outcomes_q.pop_front();
      f    = word[RES_FLAGS-1:0];
      px   = word[RES_FLAGS +: POS_BITS];
      py   = word[RES_FLAGS+POS_BITS +: POS_BITS];
      if (f.step_x !== want.flags.step_x) report_mismatch("step_x", f.step_x, want.flags.step_x);
      if (f.step_y !== want.flags.step_y) report_mismatch("step_y", f.step_y, want.flags.step_y);
      if (f.dir_x !== want.flags.dir_x) report_mismatch("dir_x", f.dir_x, want.flags.dir_x);
      if (f.dir_y !== want.flags.dir_y) report_mismatch("dir_y", f.dir_y, want.flags.dir_y);
      if (f.busy !== want.flags.busy) report_mismatch("busy", f.busy, want.flags.busy);
      if (f.done !== want.flags.done) report_mismatch("done", f.done, want.flags.done);
      if (px !== want.pos_x) report_mismatch("pos_x", px, want.pos_x);
      if (py !== want.pos_y) report_mismatch("pos_y", py, want.pos_y);
      if (word[OUT_W-1:PAD_LO] !== '0) report_mismatch("pad bits", word[OUT_W-1:PAD_LO], 0);
      checked_o++;
    end
  endtask

  // Watch all three channels; drain results before taking a new item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_x  = 1'b0;
      pol_y  = 1'b0;
      lim_x  = '1;
      lim_y  = '1;
      cur_x  = '0;
      cur_y  = '0;
      goal_x = '0;
      goal_y = '0;
      run_x  = '0;
      rise_y = '0;
      err    = '0;
      back_x = 1'b0;
      back_y = 1'b0;
      pin_x  = 1'b0;
      pin_y  = 1'b0;
      phase  = 1'b0;
      moving = 1'b0;
      step_outcomes_q.delete();
      errors_o  = 0;
      checked_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        compare_result(m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        interpolate_item(op_e'(s_axis_tuser[0]), s_axis_tuser[1],
                         s_axis_tdata[0 +: POS_BITS], s_axis_tdata[POS_BITS +: POS_BITS]);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_X_DIR_POL: pol_x = cfg_data_i[0];
          CFG_Y_DIR_POL: pol_y = cfg_data_i[0];
          CFG_X_LIMIT:   lim_x = cfg_data_i;
          CFG_Y_LIMIT:   lim_y = cfg_data_i;
          default: ;
        endcase
      end
    end
    outstanding_o = step_outcomes_q.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import xyli_pkg::*;

  localparam int unsigned POS_BITS         = 24;
  localparam int unsigned IN_W             = ((2*POS_BITS+7)/8)*8;
  localparam int unsigned OUT_W            = ((2*POS_BITS+6+7)/8)*8;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned SINK_HOLD_CYCLES = 120;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned PHASE_ITEMS      = 250;
  localparam int unsigned NUM_PHASES       = 7;
  localparam logic [POS_BITS-2:0] LIM_TOP  = '1;
  localparam logic [POS_BITS-2:0] LIM_ZERO = '0;

  typedef enum logic [1:0] {
    SQ_NONE,
    SQ_SINK_HOLD,
    SQ_SRC_PAUSE
  } squeeze_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_index_i   = CFG_X_DIR_POL;
  logic [POS_BITS-2:0]   cfg_data_i    = '0;

  int unsigned mismatches, outstanding, compared;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned moves_started = 0;
  int unsigned setups_loaded = 0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  bit          sink_hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  xy_stepper_line_interpolator #(
    .POS_BITS(POS_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  xyli_checker #(
    .POS_BITS(POS_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (mismatches),
    .outstanding_o(outstanding),
    .checked_o    (compared)
  );

  // Offer one item, after a random gap if tx_idle_en is set; return at the falling edge after its transfer
  task automatic send_item(input op_e op, input logic rel,
                           input logic signed [POS_BITS-1:0] tx,
                           input logic signed [POS_BITS-1:0] ty);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ty, tx};
    s_axis_tuser  <= {rel, op};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
    if (op == OP_START) moves_started++;
  endtask

  // Tick with junk in the unused fields
  task automatic send_tick();
    send_item(OP_TICK, 1'($urandom), POS_BITS'($urandom), POS_BITS'($urandom));
  endtask

  // Stop any move so the block ends idle
  task automatic finish_move();
    send_item(OP_START, 1'b1, '0, '0);
    send_tick();
  endtask

  // Drop valid and wait until every outcome has arrived
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [POS_BITS-2:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Write all four registers; junk in the unused polarity bits
  task automatic load_setup(input logic px, input logic py,
                            input logic [POS_BITS-2:0] lx, input logic [POS_BITS-2:0] ly);
    put_reg(CFG_X_DIR_POL, (POS_BITS-1)'(($urandom << 1) | px));
    put_reg(CFG_Y_DIR_POL, (POS_BITS-1)'(($urandom << 1) | py));
    put_reg(CFG_X_LIMIT, lx);
    put_reg(CFG_Y_LIMIT, ly);
    cfg_valid_i <= 1'b0;
    setups_loaded++;
  endtask

  // Mostly complete short moves, some abandoned or far-off ones, some stray ticks
  task automatic run_random(input int unsigned quota, input squeeze_e squeeze);
    int unsigned sent, kind, n;
    int          ox, oy, ax, ay;
    bit          squeezed;
    sent     = 0;
    squeezed = 1'b0;
    while (sent < quota) begin
      if (!squeezed && sent >= quota / 2) begin
        squeezed = 1'b1;
        if (squeeze == SQ_SINK_HOLD) begin
          sink_hold_req = 1'b1;
        end else if (squeeze == SQ_SRC_PAUSE) begin
          s_axis_tvalid <= 1'b0;
          do @(negedge clk_i); while (outstanding != 0);
        end
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        ox = $urandom_range(0, 24) - 12;
        oy = $urandom_range(0, 24) - 12;
        ax = (ox < 0) ? -ox : ox;
        ay = (oy < 0) ? -oy : oy;
        n  = 2 * ((ax > ay) ? ax : ay) + 2;
        send_item(OP_START, 1'b1, POS_BITS'(ox), POS_BITS'(oy));
        repeat (n) send_tick();
        sent += n + 1;
        n = $urandom_range(0, 2);
        repeat (n) send_tick();
        sent += n;
      end else if (kind < 75) begin
        ox = $urandom_range(0, 40) - 20;
        oy = $urandom_range(0, 40) - 20;
        n  = $urandom_range(0, 50);
        send_item(OP_START, 1'b0, POS_BITS'(ox), POS_BITS'(oy));
        repeat (n) send_tick();
        sent += n + 1;
      end else if (kind < 87) begin
        n = $urandom_range(0, 6);
        send_item(OP_START, 1'($urandom), POS_BITS'($urandom), POS_BITS'($urandom));
        repeat (n) send_tick();
        sent += n + 1;
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) send_tick();
        sent += n;
      end
    end
  endtask

  // Result side: random hold-off per result when rx_idle_en is set, plus one long hold on request
  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk_i);
      end
      gap = rx_idle_en ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
    $display("** xy_stepper_line_interpolator: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic                px, py;
    logic [POS_BITS-2:0] lx, ly;
    squeeze_e            sq;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle tick, short move to done, zero move, extreme and wrapping targets
    send_tick();
    send_item(OP_START, 1'b0, 24'sd3, -24'sd2);
    repeat (8) send_tick();
    send_item(OP_START, 1'b1, '0, '0);
    send_tick();
    send_item(OP_START, 1'b0, 24'sh800000, 24'sh7FFFFF);
    repeat (2) send_tick();
    // relative offsets that overflow from the current position; start mid-move
    send_item(OP_START, 1'b1, 24'sh7FFFFF, 24'sh800000);
    repeat (3) send_tick();
    finish_move();
    settle();

    // Random phases, each under its own register setup
    for (int p = 0; p < NUM_PHASES; p++) begin
      sq = SQ_NONE;
      px = 1'($urandom);
      py = 1'($urandom);
      lx = (POS_BITS-1)'($urandom_range(0, 24));
      ly = (POS_BITS-1)'($urandom_range(0, 24));
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      case (p)
        0: begin
          px = 1'b1;
          py = 1'b1;
          lx = LIM_TOP;
          ly = LIM_TOP;
        end
        1: begin
          px = 1'b0;
          py = 1'b1;
          lx = LIM_ZERO;
          ly = LIM_ZERO;
        end
        2: begin
          px = 1'b1;
          py = 1'b0;
          tx_idle_en = 1'b0;
          rx_idle_en = 1'b0;
          sq = SQ_SINK_HOLD;
        end
        3: begin
          lx = (POS_BITS-1)'($urandom);
          ly = (POS_BITS-1)'($urandom);
          sq = SQ_SRC_PAUSE;
        end
        4: rx_idle_en = 1'b0;
        5: tx_idle_en = 1'b0;
        default: begin
          px = 1'b0;
          py = 1'b0;
          lx = LIM_TOP;
          ly = LIM_ZERO;
        end
      endcase
      load_setup(px, py, lx, ly);
      run_random(PHASE_ITEMS, sq);
      finish_move();
      settle();
    end

    $display("coverage: %0d items sent, %0d moves started, %0d register setups",
             items_sent, moves_started, setups_loaded);
    $display("coverage: %0d results compared in %0d cycles", compared, cycle_count);
    if (mismatches == 0) begin
      $display("** xy_stepper_line_interpolator: PASSED **");
    end else begin
      $display("** xy_stepper_line_interpolator: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/xyli_pkg.sv
hdl/xyli_cfg.sv
hdl/xyli_core.sv
hdl/xy_stepper_line_interpolator.sv
hdl/xyli_checker.sv
tb/sv/xyli_checker.sv
tb/sv/tb_top.sv
